### rtl/core/tpi_pkg.sv
// Shared constants, types and the quarter-wave sine entry generator for the turtle path interpreter.
package tpi_pkg;

    localparam int unsigned STACK_DEPTH_DEF     = 64;
    localparam int unsigned SINE_INDEX_BITS_DEF = 12;

    localparam int unsigned SINE_MAG_W = 17;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned ANGLE_W    = 16;
    localparam int unsigned LETTERS    = 26;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [7:0] SYM_PLUS     = 8'h2B;
    localparam logic [7:0] SYM_MINUS    = 8'h2D;
    localparam logic [7:0] SYM_OPEN     = 8'h28;
    localparam logic [7:0] SYM_CLOSE    = 8'h29;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [1:0] KIND_SEGMENT   = 2'd0;
    localparam logic [1:0] KIND_UNDERFLOW = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_UPPER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOWER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_UPPER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_LOWER     = 3'd5;

    typedef struct packed {
        logic       start;
        logic       push;
        logic       pop;
        logic       move;
        logic       emit;
        logic [1:0] kind;
        logic       neg_c;
        logic       neg_s;
    } t_step_ctl;

    function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned k,
                                                         input int unsigned index_bits);
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] term;
        logic        [63:0] r;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(k)) >> (index_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd342; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd420; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd506; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd600; sum = sum + signed'(term);
        if (sum < 0) begin
            sum = '0;
        end
        r = (unsigned'(sum) + 64'd8192) >> 14;
        if (r > 64'd65536) begin
            r = 64'd65536;
        end
        return r[SINE_MAG_W-1:0];
    endfunction

endpackage

### rtl/core/tpi_stack.sv
// LIFO with the top entry held in a register and the entry below it prefetched from memory.
module tpi_stack #(
    parameter int unsigned DEPTH = tpi_pkg::STACK_DEPTH_DEF,
    parameter int unsigned WIDTH = tpi_pkg::ANGLE_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_push,
    input  logic                         i_pop,
    input  logic [WIDTH-1:0]             i_wdata,
    output logic [WIDTH-1:0]             o_top,
    output logic [$clog2(DEPTH+1)-1:0]   o_fill
);

    localparam int unsigned FW = $clog2(DEPTH + 1);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_top;
    logic [WIDTH-1:0] r_below;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;
    logic [FW-1:0]    base;
    logic [FW-1:0]    wr_idx;
    logic [FW-1:0]    rd_idx;

    always_comb begin
        base   = i_clear ? '0 : r_fill;
        wr_idx = base - FW'(1);
        rd_idx = base - FW'(3);
        if (i_push) begin
            n_fill = base + FW'(1);
        end else if (i_pop) begin
            n_fill = base - FW'(1);
        end else begin
            n_fill = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // spill old top below the new one
    always_ff @(posedge i_clk) begin
        if (i_push && base != '0) begin
            mem[wr_idx[AW-1:0]] <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_top   <= i_wdata;
            r_below <= r_top;
        end else if (i_pop) begin
            r_top   <= r_below;
            r_below <= mem[rd_idx[AW-1:0]];
        end
    end

    assign o_top  = r_top;
    assign o_fill = r_fill;

endmodule

### rtl/core/tpi_heading.sv
// Front stage: configuration registers, symbol decode, heading and its stack, sine lookup.
module tpi_heading #(
    parameter int unsigned STACK_DEPTH     = tpi_pkg::STACK_DEPTH_DEF,
    parameter int unsigned SINE_INDEX_BITS = tpi_pkg::SINE_INDEX_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tpi_pkg::LETTERS-1:0]       i_cfg_data,
    input  logic                              i_fire,
    input  logic [7:0]                        i_symbol,
    input  logic                              i_start_new,
    output tpi_pkg::t_step_ctl                o_ctl,
    output logic [tpi_pkg::SINE_MAG_W-1:0]    o_cos_mag,
    output logic [tpi_pkg::SINE_MAG_W-1:0]    o_sin_mag
);

    import tpi_pkg::*;

    localparam int unsigned FW     = $clog2(STACK_DEPTH + 1);
    localparam int unsigned QSTEPS = 1 << (SINE_INDEX_BITS - 2);
    localparam int unsigned RAW    = SINE_INDEX_BITS - 1;
    localparam int unsigned SHIFT  = ANGLE_W - SINE_INDEX_BITS;
    localparam logic [ANGLE_W-1:0] HALF_STEP =
        (SHIFT > 0) ? ANGLE_W'((1 << SHIFT) >> 1) : '0;

    typedef logic [SINE_MAG_W-1:0] t_rom [QSTEPS+1];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= int'(QSTEPS); k++) begin
            rom[k] = sine_entry(k, SINE_INDEX_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [ANGLE_W-1:0]         r_start_angle;
    logic [ANGLE_W-1:0]         r_turn_angle;
    logic [LETTERS-1:0]         r_alpha_up;
    logic [LETTERS-1:0]         r_alpha_lo;
    logic [LETTERS-1:0]         r_draw_up;
    logic [LETTERS-1:0]         r_draw_lo;
    logic [ANGLE_W-1:0]         r_heading;
    logic [ANGLE_W-1:0]         n_heading;
    logic [ANGLE_W-1:0]         h0;
    logic [ANGLE_W-1:0]         h_round;
    logic [ANGLE_W-1:0]         stk_top;
    logic [FW-1:0]              stk_fill;
    logic [FW-1:0]              base;
    logic [SINE_INDEX_BITS-1:0] idx_s;
    logic [SINE_INDEX_BITS-1:0] idx_c;
    logic [RAW-1:0]             addr_s;
    logic [RAW-1:0]             addr_c;
    logic [7:0]                 up_off;
    logic [7:0]                 lo_off;
    logic                       is_up;
    logic                       is_lo;
    logic                       is_plus;
    logic                       is_minus;
    logic                       is_open;
    logic                       is_close;
    logic                       full;
    logic                       empty;
    logic                       in_alpha;
    logic                       draws;
    t_step_ctl                  ctl;
    t_step_ctl                  r_ctl;
    logic [SINE_MAG_W-1:0]      r_cos_mag;
    logic [SINE_MAG_W-1:0]      r_sin_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle <= '0;
            r_turn_angle  <= '0;
            r_alpha_up    <= '0;
            r_alpha_lo    <= '0;
            r_draw_up     <= '0;
            r_draw_lo     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_ANGLE:    r_start_angle <= i_cfg_data[ANGLE_W-1:0];
                CFG_TURN_ANGLE:     r_turn_angle  <= i_cfg_data[ANGLE_W-1:0];
                CFG_ALPHABET_UPPER: r_alpha_up    <= i_cfg_data;
                CFG_ALPHABET_LOWER: r_alpha_lo    <= i_cfg_data;
                CFG_DRAW_UPPER:     r_draw_up     <= i_cfg_data;
                CFG_DRAW_LOWER:     r_draw_lo     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        h0       = i_start_new ? r_start_angle : r_heading;
        base     = i_start_new ? '0 : stk_fill;
        full     = (base == FW'(STACK_DEPTH));
        empty    = (base == '0);
        is_plus  = (i_symbol == SYM_PLUS);
        is_minus = (i_symbol == SYM_MINUS);
        is_open  = (i_symbol == SYM_OPEN);
        is_close = (i_symbol == SYM_CLOSE);
        is_up    = i_symbol inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
        is_lo    = i_symbol inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
        up_off   = i_symbol - CHAR_UPPER_A;
        lo_off   = i_symbol - CHAR_LOWER_A;
        in_alpha = (is_up && r_alpha_up[up_off[4:0]]) || (is_lo && r_alpha_lo[lo_off[4:0]]);
        draws    = (is_up && r_draw_up[up_off[4:0]]) || (is_lo && r_draw_lo[lo_off[4:0]]);

        if (is_plus) begin
            n_heading = h0 + r_turn_angle;
        end else if (is_minus) begin
            n_heading = h0 - r_turn_angle;
        end else if (is_close && !empty) begin
            n_heading = stk_top;
        end else begin
            n_heading = h0;
        end

        ctl.start = i_start_new;
        ctl.push  = is_open && !full;
        ctl.pop   = is_close && !empty;
        ctl.move  = in_alpha;
        ctl.emit  = (in_alpha && draws) || (is_open && full) || (is_close && empty);
        if (is_open && full) begin
            ctl.kind = KIND_OVERFLOW;
        end else if (is_close && empty) begin
            ctl.kind = KIND_UNDERFLOW;
        end else begin
            ctl.kind = KIND_SEGMENT;
        end

        // round heading to the table grid, fold into the first quadrant
        h_round   = h0 + HALF_STEP;
        idx_s     = h_round[ANGLE_W-1:SHIFT];
        idx_c     = idx_s + SINE_INDEX_BITS'(QSTEPS);
        ctl.neg_s = idx_s[SINE_INDEX_BITS-1];
        ctl.neg_c = idx_c[SINE_INDEX_BITS-1];
        addr_s    = idx_s[SINE_INDEX_BITS-2]
                  ? RAW'(QSTEPS) - {1'b0, idx_s[SINE_INDEX_BITS-3:0]}
                  : {1'b0, idx_s[SINE_INDEX_BITS-3:0]};
        addr_c    = idx_c[SINE_INDEX_BITS-2]
                  ? RAW'(QSTEPS) - {1'b0, idx_c[SINE_INDEX_BITS-3:0]}
                  : {1'b0, idx_c[SINE_INDEX_BITS-3:0]};
    end

    tpi_stack #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (ANGLE_W)
    ) u_heading_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_fire && i_start_new),
        .i_push  (i_fire && ctl.push),
        .i_pop   (i_fire && ctl.pop),
        .i_wdata (h0),
        .o_top   (stk_top),
        .o_fill  (stk_fill)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
        end else if (i_fire) begin
            r_heading <= n_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_ctl     <= ctl;
            r_cos_mag <= SINE_ROM[addr_c];
            r_sin_mag <= SINE_ROM[addr_s];
        end
    end

    assign o_ctl     = r_ctl;
    assign o_cos_mag = r_cos_mag;
    assign o_sin_mag = r_sin_mag;

endmodule

### rtl/core/tpi_pen.sv
// Back stage: pen position, its stack, saturating step and the result register.
module tpi_pen #(
    parameter int unsigned STACK_DEPTH = tpi_pkg::STACK_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  tpi_pkg::t_step_ctl                 i_ctl,
    input  logic [tpi_pkg::SINE_MAG_W-1:0]     i_cos_mag,
    input  logic [tpi_pkg::SINE_MAG_W-1:0]     i_sin_mag,
    input  logic                               i_out_ready,
    output logic                               o_ready,
    output logic                               o_out_valid,
    output logic [1:0]                         o_kind,
    output logic signed [tpi_pkg::COORD_W-1:0] o_from_x,
    output logic signed [tpi_pkg::COORD_W-1:0] o_from_y,
    output logic signed [tpi_pkg::COORD_W-1:0] o_to_x,
    output logic signed [tpi_pkg::COORD_W-1:0] o_to_y
);

    import tpi_pkg::*;

    localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

    logic                       r_s2_valid;
    logic                       r_out_valid;
    logic                       out_free;
    logic                       s2_fire;
    logic signed [COORD_W-1:0]  r_pen_x;
    logic signed [COORD_W-1:0]  r_pen_y;
    logic signed [COORD_W-1:0]  p0_x;
    logic signed [COORD_W-1:0]  p0_y;
    logic signed [COORD_W-1:0]  step_x;
    logic signed [COORD_W-1:0]  step_y;
    logic signed [COORD_W-1:0]  n_pen_x;
    logic signed [COORD_W-1:0]  n_pen_y;
    logic signed [COORD_W:0]    sum_x;
    logic signed [COORD_W:0]    sum_y;
    logic signed [SINE_MAG_W:0] dx;
    logic signed [SINE_MAG_W:0] dy;
    logic [2*COORD_W-1:0]       stk_top;
    logic [FW-1:0]              stk_fill;
    logic [1:0]                 r_kind;
    logic signed [COORD_W-1:0]  r_from_x;
    logic signed [COORD_W-1:0]  r_from_y;
    logic signed [COORD_W-1:0]  r_to_x;
    logic signed [COORD_W-1:0]  r_to_y;

    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        s2_fire  = r_s2_valid && (!i_ctl.emit || out_free);
        o_ready  = !r_s2_valid || s2_fire;

        p0_x  = i_ctl.start ? '0 : r_pen_x;
        p0_y  = i_ctl.start ? '0 : r_pen_y;
        dx    = i_ctl.neg_c ? -signed'({1'b0, i_cos_mag}) : signed'({1'b0, i_cos_mag});
        dy    = i_ctl.neg_s ? -signed'({1'b0, i_sin_mag}) : signed'({1'b0, i_sin_mag});
        sum_x = (COORD_W+1)'(p0_x) + (COORD_W+1)'(dx);
        sum_y = (COORD_W+1)'(p0_y) + (COORD_W+1)'(dy);

        // clamp to the signed coordinate range
        if (sum_x[COORD_W] != sum_x[COORD_W-1]) begin
            step_x = sum_x[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            step_x = sum_x[COORD_W-1:0];
        end
        if (sum_y[COORD_W] != sum_y[COORD_W-1]) begin
            step_y = sum_y[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            step_y = sum_y[COORD_W-1:0];
        end

        if (i_ctl.move) begin
            n_pen_x = step_x;
            n_pen_y = step_y;
        end else if (i_ctl.pop) begin
            n_pen_x = stk_top[COORD_W-1:0];
            n_pen_y = stk_top[2*COORD_W-1:COORD_W];
        end else begin
            n_pen_x = p0_x;
            n_pen_y = p0_y;
        end
    end

    tpi_stack #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (2*COORD_W)
    ) u_pen_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (s2_fire && i_ctl.start),
        .i_push  (s2_fire && i_ctl.push),
        .i_pop   (s2_fire && i_ctl.pop),
        .i_wdata ({p0_y, p0_x}),
        .o_top   (stk_top),
        .o_fill  (stk_fill)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
        end else begin
            if (i_load) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire && i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_pen_x <= n_pen_x;
                r_pen_y <= n_pen_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && i_ctl.emit) begin
            r_kind   <= i_ctl.kind;
            r_from_x <= p0_x;
            r_from_y <= p0_y;
            r_to_x   <= n_pen_x;
            r_to_y   <= n_pen_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_from_x    = r_from_x;
    assign o_from_y    = r_from_y;
    assign o_to_x      = r_to_x;
    assign o_to_y      = r_to_y;

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && i_ctl.pop) |-> (!i_ctl.start && stk_fill != '0))
        else $error("pen stack popped while empty");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && i_ctl.push && !i_ctl.start) |-> (stk_fill != FW'(STACK_DEPTH)))
        else $error("pen stack pushed while full");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_s2_valid && i_ctl.emit && r_out_valid && !i_out_ready))
        else $error("back stage stalled without a blocked result");

    a_fault_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && i_ctl.emit && i_ctl.kind != KIND_SEGMENT)
            |-> (!i_ctl.move && !i_ctl.push && !i_ctl.pop))
        else $error("stack fault combined with a pen update");

    a_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $onehot0({i_ctl.move, i_ctl.push, i_ctl.pop}))
        else $error("more than one pen operation in a step");

endmodule

### rtl/core/turtle_path_interpreter.sv
// Top level of the turtle path interpreter: stream ports, configuration port, two-stage datapath.
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: symbol; tuser: start_new
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: from/to x,y; tuser: kind
//  cfg       in   i_cfg_we                         i_cfg_idx, i_cfg_data
//
//  One symbol per cycle unless m_axis stalls the input; each result is held in the back stage result register.
//  The front stage updates heading and the heading stack in the accepting cycle and
//  reads the sine table; the back stage updates the pen and the pen stack from the registered step.
//  Reset is synchronous, active low; no clearing pass, the stacks start empty.
//  A stall on m_axis blocks input only while a result waits and the next step emits.
module turtle_path_interpreter #(
    parameter int unsigned STACK_DEPTH     = tpi_pkg::STACK_DEPTH_DEF,
    parameter int unsigned SINE_INDEX_BITS = tpi_pkg::SINE_INDEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tpi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpi_pkg::LETTERS-1:0]   i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // [7:0] symbol
    input  logic [0:0]                    i_s_axis_tuser,  // [0] start_new
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [127:0]                  o_m_axis_tdata,  // from_x, from_y, to_x, to_y
    output logic [1:0]                    o_m_axis_tuser   // [1:0] kind
);

    import tpi_pkg::*;

    t_step_ctl                        ctl;
    logic [SINE_MAG_W-1:0]            cos_mag;
    logic [SINE_MAG_W-1:0]            sin_mag;
    logic                             s_fire;
    logic                             s2_ready;
    logic signed [COORD_W-1:0]        from_x;
    logic signed [COORD_W-1:0]        from_y;
    logic signed [COORD_W-1:0]        to_x;
    logic signed [COORD_W-1:0]        to_y;

    assign o_s_axis_tready = s2_ready;
    assign s_fire          = i_s_axis_tvalid && s2_ready;

    tpi_heading #(
        .STACK_DEPTH     (STACK_DEPTH),
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_heading (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (s_fire),
        .i_symbol    (i_s_axis_tdata),
        .i_start_new (i_s_axis_tuser[0]),
        .o_ctl       (ctl),
        .o_cos_mag   (cos_mag),
        .o_sin_mag   (sin_mag)
    );

    tpi_pen #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_pen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_fire),
        .i_ctl       (ctl),
        .i_cos_mag   (cos_mag),
        .i_sin_mag   (sin_mag),
        .i_out_ready (i_m_axis_tready),
        .o_ready     (s2_ready),
        .o_out_valid (o_m_axis_tvalid),
        .o_kind      (o_m_axis_tuser),
        .o_from_x    (from_x),
        .o_from_y    (from_y),
        .o_to_x      (to_x),
        .o_to_y      (to_y)
    );

    assign o_m_axis_tdata = {to_y, to_x, from_y, from_x};

endmodule
